// ----- design/rtie_pkg.sv -----
`timescale 1ns / 1ps
package rtie_pkg;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVF      = 2'd1,
		ST_MISALIGN = 2'd2,
		ST_INVALID  = 2'd3
	} status_t;

	typedef enum logic [5:0] {
		FN_SLL   = 6'h00,
		FN_SRL   = 6'h02,
		FN_SRA   = 6'h03,
		FN_SLLV  = 6'h04,
		FN_SRLV  = 6'h06,
		FN_SRAV  = 6'h07,
		FN_JR    = 6'h08,
		FN_JALR  = 6'h09,
		FN_MFHI  = 6'h10,
		FN_MTHI  = 6'h11,
		FN_MFLO  = 6'h12,
		FN_MTLO  = 6'h13,
		FN_MULT  = 6'h18,
		FN_MULTU = 6'h19,
		FN_DIV   = 6'h1A,
		FN_DIVU  = 6'h1B,
		FN_ADD   = 6'h20,
		FN_ADDU  = 6'h21,
		FN_SUB   = 6'h22,
		FN_SUBU  = 6'h23,
		FN_AND   = 6'h24,
		FN_OR    = 6'h25,
		FN_XOR   = 6'h26,
		FN_SLT   = 6'h2A,
		FN_SLTU  = 6'h2B
	} funct_t;

	// decoded item handed from front to back
	typedef struct packed {
		logic [5:0]  fn;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  rd;
		logic [4:0]  sh;
		logic        invalid;
		logic [31:0] pc;
	} dec_t;

	typedef enum logic [2:0] {
		EX_IDLE,
		EX_READ,
		EX_MUL,
		EX_DIV,
		EX_DONE
	} ex_state_t;

	localparam int DecW = $bits(dec_t);

endpackage

// ----- design/rtie_front.sv -----
`timescale 1ns / 1ps
module rtie_front #(
	parameter int Depth = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [31:0]          instr_word,
	input  logic [31:0]          current_pc,
	output logic                 dq_valid,
	input  logic                 dq_take,
	output rtie_pkg::dec_t       dq_item
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	rtie_pkg::dec_t       fifo_q [Depth];
	logic [AW-1:0]        wptr_q, rptr_q;
	logic [AW:0]          cnt_q;
	rtie_pkg::dec_t       dec;
	logic                 inv;
	logic [4:0]           rs, rt, rd, sh;
	logic                 wr_en, rd_en;

	assign rs = instr_word[25:21];
	assign rt = instr_word[20:16];
	assign rd = instr_word[15:11];
	assign sh = instr_word[10:6];

	// format checks; divu with zero divisor is settled in the back end
	always_comb begin
		inv = 1'b0;
		unique case (instr_word[5:0])
			rtie_pkg::FN_SLL, rtie_pkg::FN_SRL, rtie_pkg::FN_SRA: inv = (rs != 5'd0);
			rtie_pkg::FN_SLLV, rtie_pkg::FN_SRLV, rtie_pkg::FN_SRAV,
			rtie_pkg::FN_ADD, rtie_pkg::FN_ADDU, rtie_pkg::FN_SUB, rtie_pkg::FN_SUBU,
			rtie_pkg::FN_AND, rtie_pkg::FN_OR, rtie_pkg::FN_XOR,
			rtie_pkg::FN_SLT, rtie_pkg::FN_SLTU: inv = (sh != 5'd0);
			rtie_pkg::FN_JR:   inv = (rs != 5'd0) && (rt != 5'd0) && (sh != 5'd0);
			rtie_pkg::FN_JALR: inv = (rt != 5'd0) && (sh != 5'd0);
			rtie_pkg::FN_MFHI, rtie_pkg::FN_MFLO:
				inv = (rs != 5'd0) || (rt != 5'd0) || (sh != 5'd0);
			rtie_pkg::FN_MTHI, rtie_pkg::FN_MTLO:
				inv = (rt != 5'd0) || (rd != 5'd0) || (sh != 5'd0);
			rtie_pkg::FN_MULT, rtie_pkg::FN_MULTU, rtie_pkg::FN_DIV, rtie_pkg::FN_DIVU:
				inv = (rd != 5'd0) || (sh != 5'd0);
			default: inv = 1'b1;
		endcase
	end

	always_comb begin
		dec.fn      = instr_word[5:0];
		dec.rs      = rs;
		dec.rt      = rt;
		dec.rd      = rd;
		dec.sh      = sh;
		dec.invalid = inv;
		dec.pc      = current_pc;
	end

	assign full     = (cnt_q == (AW+1)'(Depth));
	assign dq_valid = (cnt_q != '0);
	assign wr_en    = push && !full;
	assign rd_en    = dq_take && dq_valid;
	assign dq_item  = fifo_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) fifo_q[wptr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) wptr_q <= (wptr_q == AW'(Depth-1)) ? '0 : wptr_q + 1'b1;
			if (rd_en) rptr_q <= (rptr_q == AW'(Depth-1)) ? '0 : rptr_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
		end
	end
endmodule

// ----- design/rtie_divider.sv -----
`timescale 1ns / 1ps
module rtie_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quot,
	output logic [31:0] rem
);
	// restoring divide, one quotient bit per cycle
	logic [31:0] q_q, r_q, d_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {r_q, q_q[31]};
	assign trial   = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				r_q <= trial[31:0];
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= shifted[31:0];
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
	assign rem  = r_q;
endmodule

// ----- design/rtie_back.sv -----
`timescale 1ns / 1ps
module rtie_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 dq_valid,
	output logic                 dq_take,
	input  rtie_pkg::dec_t       dq_item,
	output logic                 empty,
	input  logic                 pop,
	output logic [31:0]          next_pc,
	output logic                 delay_slot_pending,
	output logic [31:0]          delay_slot_pc,
	output logic                 reg_write_en,
	output logic [4:0]           reg_write_index,
	output logic [31:0]          reg_write_value,
	output logic [1:0]           status
);
	rtie_pkg::ex_state_t state_q, state_d;
	rtie_pkg::dec_t      it_s1;
	logic [31:0]         gpr_q [32];
	logic [31:0]         hi_q, lo_q;
	logic [31:0]         a_s1, b_s1;
	logic                out_v_q;

	// multiply: 32x32 unsigned product registered in the read state, then the signed
	// correction of the upper half registered in the multiply state
	logic [31:0]         mul_fix;
	logic [63:0]         pp_lo_q, pp_hi_q;
	logic                mul_ph_q;
	logic [63:0]         prod;

	logic [31:0]         ma, mb;
	logic                div_start, div_done;
	logic [31:0]         dq, dr;
	logic [31:0]         q_fix, r_fix;

	// combinational result of all operations
	logic [31:0]         wv, npc;
	logic [1:0]          st;
	logic                wr, jmp, set_hi, set_lo;
	logic [31:0]         nhi, nlo;
	logic [32:0]         sum;
	logic [4:0]          samt;
	logic                sgn_div, div_zero;

	assign div_zero = (b_s1 == 32'd0);
	assign sgn_div  = (it_s1.fn == rtie_pkg::FN_DIV);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rtie_pkg::EX_IDLE: if (dq_valid) state_d = rtie_pkg::EX_READ;
			rtie_pkg::EX_READ: begin
				if (!it_s1.invalid &&
				    (it_s1.fn == rtie_pkg::FN_MULT || it_s1.fn == rtie_pkg::FN_MULTU))
					state_d = rtie_pkg::EX_MUL;
				else if (it_s1.fn == rtie_pkg::FN_DIVU && div_zero)
					state_d = rtie_pkg::EX_DONE;
				else if (!it_s1.invalid && (it_s1.fn == rtie_pkg::FN_DIVU ||
				         (sgn_div && !div_zero &&
				          !(a_s1 == 32'h8000_0000 && b_s1 == 32'hFFFF_FFFF))))
					state_d = rtie_pkg::EX_DIV;
				else
					state_d = rtie_pkg::EX_DONE;
			end
			rtie_pkg::EX_MUL: if (mul_ph_q) state_d = rtie_pkg::EX_DONE;
			rtie_pkg::EX_DIV: if (div_done) state_d = rtie_pkg::EX_DONE;
			rtie_pkg::EX_DONE: if (!out_v_q || pop) state_d = rtie_pkg::EX_IDLE;
			default: state_d = rtie_pkg::EX_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		dq_take   = (state_q == rtie_pkg::EX_IDLE) && dq_valid;
		div_start = (state_q == rtie_pkg::EX_READ) && (state_d == rtie_pkg::EX_DIV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rtie_pkg::EX_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (dq_take) it_s1 <= dq_item;
	end

	// operand read from register file, zero register forced
	always_ff @(posedge clk) begin
		if (dq_take) begin
			a_s1 <= (dq_item.rs == 5'd0) ? 32'd0 : gpr_q[dq_item.rs];
			b_s1 <= (dq_item.rt == 5'd0) ? 32'd0 : gpr_q[dq_item.rt];
		end
	end

	// signed product: subtract b when a is negative and a when b is negative
	assign mul_fix = (it_s1.fn == rtie_pkg::FN_MULT) ?
		((a_s1[31] ? (~b_s1 + 32'd1) : 32'd0) + (b_s1[31] ? (~a_s1 + 32'd1) : 32'd0)) :
		32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mul_ph_q <= 1'b0;
		else         mul_ph_q <= (state_q == rtie_pkg::EX_MUL) && !mul_ph_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == rtie_pkg::EX_READ) pp_lo_q <= {32'd0, a_s1} * {32'd0, b_s1};
		if (state_q == rtie_pkg::EX_MUL && !mul_ph_q)
			pp_hi_q <= {mul_fix, 32'd0};
	end
	assign prod = pp_lo_q + pp_hi_q;

	assign ma = (sgn_div && a_s1[31]) ? (~a_s1 + 32'd1) : a_s1;
	assign mb = (sgn_div && b_s1[31]) ? (~b_s1 + 32'd1) : b_s1;

	rtie_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ma),
		.divisor  (mb),
		.done     (div_done),
		.quot     (dq),
		.rem      (dr)
	);

	assign q_fix = (sgn_div && (a_s1[31] ^ b_s1[31])) ? (~dq + 32'd1) : dq;
	assign r_fix = (sgn_div && a_s1[31]) ? (~dr + 32'd1) : dr;

	always_comb begin
		st     = rtie_pkg::ST_OK;
		wv     = 32'd0;
		wr     = 1'b0;
		jmp    = 1'b0;
		npc    = it_s1.pc + 32'd4;
		set_hi = 1'b0;
		set_lo = 1'b0;
		nhi    = a_s1;
		nlo    = a_s1;
		sum    = 33'd0;
		samt   = (it_s1.fn[2]) ? a_s1[4:0] : it_s1.sh;
		if (it_s1.fn == rtie_pkg::FN_DIVU && div_zero) begin
			set_hi = 1'b1; set_lo = 1'b1; nhi = 32'd0; nlo = 32'd0;
		end else if (it_s1.invalid) begin
			st = rtie_pkg::ST_INVALID;
		end else begin
			unique case (it_s1.fn)
				rtie_pkg::FN_SLL, rtie_pkg::FN_SLLV: begin wv = b_s1 << samt; wr = 1'b1; end
				rtie_pkg::FN_SRL, rtie_pkg::FN_SRLV: begin wv = b_s1 >> samt; wr = 1'b1; end
				rtie_pkg::FN_SRA, rtie_pkg::FN_SRAV: begin
					wv = 32'($signed(b_s1) >>> samt); wr = 1'b1;
				end
				rtie_pkg::FN_JR, rtie_pkg::FN_JALR: begin
					if (a_s1[1:0] != 2'b00) st = rtie_pkg::ST_MISALIGN;
					else begin
						jmp = 1'b1;
						npc = a_s1;
						wr  = (it_s1.fn == rtie_pkg::FN_JALR);
						wv  = it_s1.pc + 32'd8;
					end
				end
				rtie_pkg::FN_MFHI: begin wv = hi_q; wr = 1'b1; end
				rtie_pkg::FN_MFLO: begin wv = lo_q; wr = 1'b1; end
				rtie_pkg::FN_MTHI: set_hi = 1'b1;
				rtie_pkg::FN_MTLO: set_lo = 1'b1;
				rtie_pkg::FN_MULT, rtie_pkg::FN_MULTU: begin
					set_hi = 1'b1; set_lo = 1'b1; nhi = prod[63:32]; nlo = prod[31:0];
				end
				rtie_pkg::FN_DIV, rtie_pkg::FN_DIVU: begin
					set_hi = 1'b1; set_lo = 1'b1;
					if (div_zero || (sgn_div && a_s1 == 32'h8000_0000 &&
					    b_s1 == 32'hFFFF_FFFF)) begin
						nhi = 32'd0; nlo = 32'd0;
					end else begin
						nhi = r_fix; nlo = q_fix;
					end
				end
				rtie_pkg::FN_ADD, rtie_pkg::FN_ADDU: begin
					sum = {1'b0, a_s1} + {1'b0, b_s1};
					wv  = sum[31:0];
					wr  = 1'b1;
					if (it_s1.fn == rtie_pkg::FN_ADD &&
					    (~(a_s1[31] ^ b_s1[31]) & (a_s1[31] ^ wv[31]))) begin
						st = rtie_pkg::ST_OVF; wr = 1'b0;
					end
				end
				rtie_pkg::FN_SUB, rtie_pkg::FN_SUBU: begin
					sum = {1'b0, a_s1} - {1'b0, b_s1};
					wv  = sum[31:0];
					wr  = 1'b1;
					if (it_s1.fn == rtie_pkg::FN_SUB &&
					    ((a_s1[31] ^ b_s1[31]) & (a_s1[31] ^ wv[31]))) begin
						st = rtie_pkg::ST_OVF; wr = 1'b0;
					end
				end
				rtie_pkg::FN_AND: begin wv = a_s1 & b_s1; wr = 1'b1; end
				rtie_pkg::FN_OR:  begin wv = a_s1 | b_s1; wr = 1'b1; end
				rtie_pkg::FN_XOR: begin wv = a_s1 ^ b_s1; wr = 1'b1; end
				rtie_pkg::FN_SLT: begin
					wv = {31'd0, $signed(a_s1) < $signed(b_s1)}; wr = 1'b1;
				end
				rtie_pkg::FN_SLTU: begin wv = {31'd0, a_s1 < b_s1}; wr = 1'b1; end
				default: st = rtie_pkg::ST_INVALID;
			endcase
		end
		if (st != rtie_pkg::ST_OK) begin
			set_hi = 1'b0; set_lo = 1'b0; wr = 1'b0; jmp = 1'b0;
			npc = it_s1.pc;
		end
		if (it_s1.rd == 5'd0) wr = 1'b0;
	end

	// commit: state update and result register on leaving the done state
	logic commit;
	assign commit = (state_q == rtie_pkg::EX_DONE) && (!out_v_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q <= '0;
			lo_q <= '0;
			for (int i = 0; i < 32; i++) gpr_q[i] <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (commit) begin
				if (set_hi) hi_q <= nhi;
				if (set_lo) lo_q <= nlo;
				if (wr) gpr_q[it_s1.rd] <= wv;
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			next_pc            <= npc;
			delay_slot_pending <= jmp;
			delay_slot_pc      <= jmp ? it_s1.pc + 32'd4 : 32'd0;
			reg_write_en       <= wr;
			reg_write_index    <= wr ? it_s1.rd : 5'd0;
			reg_write_value    <= wr ? wv : 32'd0;
			status             <= st;
		end
	end

	assign empty = !out_v_q;
endmodule

// ----- design/r_type_instruction_execute_core.sv -----
`timescale 1ns / 1ps
// flow: an item is queued, then taken by the back-end sequencer, which reads the
// operands, multiplies or divides where needed (one quotient bit a cycle in the divider)
// and commits the result to the output register; the queue accepts new items until
// full while the back-end sequencer handles one item at a time
// reset: arst_n clears queues, register file, hi and lo at once
module r_type_instruction_execute_core #(
	parameter int QueueDepth = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] instr_word,
	input  logic [31:0] current_pc,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] next_pc,
	output logic        delay_slot_pending,
	output logic [31:0] delay_slot_pc,
	output logic        reg_write_en,
	output logic [4:0]  reg_write_index,
	output logic [31:0] reg_write_value,
	output logic [1:0]  status
);
	logic           dq_valid, dq_take;
	rtie_pkg::dec_t dq_item;

	rtie_front #(.Depth(QueueDepth)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.instr_word (instr_word),
		.current_pc (current_pc),
		.dq_valid   (dq_valid),
		.dq_take    (dq_take),
		.dq_item    (dq_item)
	);

	rtie_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.dq_valid           (dq_valid),
		.dq_take            (dq_take),
		.dq_item            (dq_item),
		.empty              (empty),
		.pop                (pop),
		.next_pc            (next_pc),
		.delay_slot_pending (delay_slot_pending),
		.delay_slot_pc      (delay_slot_pc),
		.reg_write_en       (reg_write_en),
		.reg_write_index    (reg_write_index),
		.reg_write_value    (reg_write_value),
		.status             (status)
	);
endmodule

// ----- design/rtie_checker.sv -----
`timescale 1ns / 1ps
module rtie_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [31:0] next_pc,
	input logic        delay_slot_pending,
	input logic        reg_write_en,
	input logic [4:0]  reg_write_index,
	input logic [1:0]  status
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(next_pc))
		else $error("waiting item changed");

	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status != rtie_pkg::ST_OK |-> !reg_write_en && !delay_slot_pending)
		else $error("error item shows side effects");

	a_no_r0: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && reg_write_en |-> reg_write_index != 5'd0)
		else $error("write to register zero");

	a_jump_align: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && delay_slot_pending |-> next_pc[1:0] == 2'b00)
		else $error("misaligned jump taken");
endmodule

bind r_type_instruction_execute_core rtie_checker u_chk (
	.clk                (clk),
	.arst_n             (arst_n),
	.empty              (empty),
	.pop                (pop),
	.next_pc            (next_pc),
	.delay_slot_pending (delay_slot_pending),
	.reg_write_en       (reg_write_en),
	.reg_write_index    (reg_write_index),
	.status             (status)
);

// ----- tb/tb_r_type_instruction_execute_core.sv -----
`timescale 1ns / 1ps
module tb_r_type_instruction_execute_core;

	typedef struct {
		logic [31:0] instr;
		logic [31:0] pc;
	} instr_item_t;

	typedef struct {
		logic [31:0]       npc;
		logic              dsp;
		logic [31:0]       dspc;
		logic              we;
		logic [4:0]        widx;
		logic [31:0]       wval;
		rtie_pkg::status_t st;
	} exec_result_t;

	localparam int CycleLimit = 200000;
	localparam int NumRandom  = 405;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        push = 0;
	logic        pop = 0;
	logic [31:0] instr_word = '0;
	logic [31:0] current_pc = '0;
	logic        full, empty;
	logic [31:0] next_pc, delay_slot_pc, reg_write_value;
	logic        delay_slot_pending, reg_write_en;
	logic [4:0]  reg_write_index;
	logic [1:0]  status;

	r_type_instruction_execute_core uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.instr_word(instr_word), .current_pc(current_pc),
		.empty(empty), .pop(pop), .next_pc(next_pc),
		.delay_slot_pending(delay_slot_pending), .delay_slot_pc(delay_slot_pc),
		.reg_write_en(reg_write_en), .reg_write_index(reg_write_index),
		.reg_write_value(reg_write_value), .status(status)
	);

	always #5 clk = ~clk;

	instr_item_t  pending_instrs[$];
	exec_result_t expected_results[$];
	exec_result_t exp_r;
	logic [31:0]  gpr_model[32];
	logic [31:0]  hi_model, lo_model;
	int           errors = 0;
	int           accepted = 0;
	int           retired = 0;
	int           total_items = 0;
	int           cycles = 0;
	int           n_ovf = 0, n_misalign = 0, n_invalid = 0, n_jump = 0;
	int           burst_left = 0, gap_left = 0, pop_cnt = 0;
	bit           gen_done = 0;
	bit           long_hold = 0;
	bit           long_hold_done = 0;
	bit           last_acc = 0;
	bit           full_seen = 0;

	function automatic logic [31:0] read_gpr(logic [4:0] i);
		return (i == 5'd0) ? 32'd0 : gpr_model[i];
	endfunction

	function automatic logic [31:0] mk(rtie_pkg::funct_t fn, int rs, int rt, int rd, int sh);
		return {6'd0, 5'(rs), 5'(rt), 5'(rd), 5'(sh), 6'(fn)};
	endfunction

	// computes one instruction's outcome and updates the register/hi/lo copy
	function automatic exec_result_t execute_instr(logic [31:0] w, logic [31:0] pc);
		exec_result_t      r;
		logic [4:0]        rs, rt, rd, sh;
		logic [5:0]        fn;
		logic [31:0]       a, b, wv, npc, nhi, nlo, q, rm, ma, mb;
		logic [63:0]       p;
		rtie_pkg::status_t st;
		logic              wr, jmp;
		rs = w[25:21]; rt = w[20:16]; rd = w[15:11]; sh = w[10:6]; fn = w[5:0];
		a = read_gpr(rs); b = read_gpr(rt);
		st = rtie_pkg::ST_OK; npc = pc + 32'd4; wv = 0; nhi = hi_model; nlo = lo_model;
		wr = 0; jmp = 0;
		unique case (fn)
			rtie_pkg::FN_SLL, rtie_pkg::FN_SRL, rtie_pkg::FN_SRA: begin
				if (rs != 0) st = rtie_pkg::ST_INVALID;
				else begin
					wv = (fn == rtie_pkg::FN_SLL) ? b << sh :
						(fn == rtie_pkg::FN_SRL) ? b >> sh : 32'($signed(b) >>> sh);
					wr = 1;
				end
			end
			rtie_pkg::FN_SLLV, rtie_pkg::FN_SRLV, rtie_pkg::FN_SRAV: begin
				if (sh != 0) st = rtie_pkg::ST_INVALID;
				else begin
					wv = (fn == rtie_pkg::FN_SLLV) ? b << a[4:0] :
						(fn == rtie_pkg::FN_SRLV) ? b >> a[4:0] :
						32'($signed(b) >>> a[4:0]);
					wr = 1;
				end
			end
			rtie_pkg::FN_JR, rtie_pkg::FN_JALR: begin
				if ((fn == rtie_pkg::FN_JR) ? (rs != 0 && rt != 0 && sh != 0) :
				    (rt != 0 && sh != 0))
					st = rtie_pkg::ST_INVALID;
				else if (a[1:0] != 2'b00) st = rtie_pkg::ST_MISALIGN;
				else begin
					jmp = 1; npc = a;
					if (fn == rtie_pkg::FN_JALR) begin
						wr = 1; wv = pc + 32'd8;
					end
				end
			end
			rtie_pkg::FN_MFHI, rtie_pkg::FN_MFLO: begin
				if (rs != 0 || rt != 0 || sh != 0) st = rtie_pkg::ST_INVALID;
				else begin
					wv = (fn == rtie_pkg::FN_MFHI) ? hi_model : lo_model; wr = 1;
				end
			end
			rtie_pkg::FN_MTHI, rtie_pkg::FN_MTLO: begin
				if (rt != 0 || rd != 0 || sh != 0) st = rtie_pkg::ST_INVALID;
				else if (fn == rtie_pkg::FN_MTHI) nhi = a;
				else nlo = a;
			end
			rtie_pkg::FN_MULT, rtie_pkg::FN_MULTU: begin
				if (rd != 0 || sh != 0) st = rtie_pkg::ST_INVALID;
				else begin
					if (fn == rtie_pkg::FN_MULT)
						p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
					else
						p = {32'd0, a} * {32'd0, b};
					nlo = p[31:0]; nhi = p[63:32];
				end
			end
			rtie_pkg::FN_DIV: begin
				if (rd != 0 || sh != 0) st = rtie_pkg::ST_INVALID;
				else if (b == 0 || (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)) begin
					nhi = 0; nlo = 0;
				end else begin
					ma = a[31] ? (~a + 32'd1) : a;
					mb = b[31] ? (~b + 32'd1) : b;
					q = ma / mb;
					rm = ma % mb;
					nlo = (a[31] ^ b[31]) ? (~q + 32'd1) : q;
					nhi = a[31] ? (~rm + 32'd1) : rm;
				end
			end
			rtie_pkg::FN_DIVU: begin
				if (b == 0) begin
					nhi = 0; nlo = 0;
				end else if (rd != 0 || sh != 0) st = rtie_pkg::ST_INVALID;
				else begin
					nlo = a / b; nhi = a % b;
				end
			end
			rtie_pkg::FN_ADD, rtie_pkg::FN_ADDU, rtie_pkg::FN_SUB, rtie_pkg::FN_SUBU,
			rtie_pkg::FN_AND, rtie_pkg::FN_OR, rtie_pkg::FN_XOR, rtie_pkg::FN_SLT,
			rtie_pkg::FN_SLTU: begin
				if (sh != 0) st = rtie_pkg::ST_INVALID;
				else begin
					unique case (fn)
						rtie_pkg::FN_ADD, rtie_pkg::FN_ADDU: begin
							wv = a + b;
							if (fn == rtie_pkg::FN_ADD &&
							    (~(a ^ b) & (a ^ wv) & 32'h8000_0000) != 0)
								st = rtie_pkg::ST_OVF;
						end
						rtie_pkg::FN_SUB, rtie_pkg::FN_SUBU: begin
							wv = a - b;
							if (fn == rtie_pkg::FN_SUB &&
							    ((a ^ b) & (a ^ wv) & 32'h8000_0000) != 0)
								st = rtie_pkg::ST_OVF;
						end
						rtie_pkg::FN_AND: wv = a & b;
						rtie_pkg::FN_OR:  wv = a | b;
						rtie_pkg::FN_XOR: wv = a ^ b;
						rtie_pkg::FN_SLT: wv = {31'd0, $signed(a) < $signed(b)};
						default: wv = {31'd0, a < b};
					endcase
					if (st == rtie_pkg::ST_OK) wr = 1;
				end
			end
			default: st = rtie_pkg::ST_INVALID;
		endcase
		r = '{npc: pc, dsp: 0, dspc: 0, we: 0, widx: 0, wval: 0, st: st};
		if (st != rtie_pkg::ST_OK) return r;
		hi_model = nhi; lo_model = nlo;
		if (wr && rd == 0) wr = 0;
		if (wr) gpr_model[rd] = wv;
		r.npc = npc; r.dsp = jmp; r.dspc = jmp ? pc + 32'd4 : 32'd0;
		r.we = wr; r.widx = wr ? rd : 5'd0; r.wval = wr ? wv : 32'd0;
		return r;
	endfunction

	function automatic logic [31:0] rand_instr();
		rtie_pkg::funct_t ops[25] = '{rtie_pkg::FN_SLL, rtie_pkg::FN_SRL,
			rtie_pkg::FN_SRA, rtie_pkg::FN_SLLV, rtie_pkg::FN_SRLV, rtie_pkg::FN_SRAV,
			rtie_pkg::FN_JR, rtie_pkg::FN_JALR, rtie_pkg::FN_MFHI, rtie_pkg::FN_MTHI,
			rtie_pkg::FN_MFLO, rtie_pkg::FN_MTLO, rtie_pkg::FN_MULT, rtie_pkg::FN_MULTU,
			rtie_pkg::FN_DIV, rtie_pkg::FN_DIVU, rtie_pkg::FN_ADD, rtie_pkg::FN_ADDU,
			rtie_pkg::FN_SUB, rtie_pkg::FN_SUBU, rtie_pkg::FN_AND, rtie_pkg::FN_OR,
			rtie_pkg::FN_XOR, rtie_pkg::FN_SLT, rtie_pkg::FN_SLTU};
		rtie_pkg::funct_t fn;
		int rs, rt, rd, sh, k;
		k = $urandom_range(99);
		if (k < 8) return $urandom();
		fn = ops[$urandom_range(24)];
		rs = $urandom_range(31); rt = $urandom_range(31);
		rd = $urandom_range(31); sh = $urandom_range(31);
		// mostly well-formed: clear the fields the format wants zero
		if (k < 85) begin
			unique case (fn)
				rtie_pkg::FN_SLL, rtie_pkg::FN_SRL, rtie_pkg::FN_SRA: rs = 0;
				rtie_pkg::FN_MFHI, rtie_pkg::FN_MFLO: begin rs = 0; rt = 0; sh = 0; end
				rtie_pkg::FN_MTHI, rtie_pkg::FN_MTLO: begin rt = 0; rd = 0; sh = 0; end
				rtie_pkg::FN_MULT, rtie_pkg::FN_MULTU, rtie_pkg::FN_DIV,
				rtie_pkg::FN_DIVU: begin rd = 0; sh = 0; end
				rtie_pkg::FN_JR: begin rt = 0; sh = 0; end
				// link from r0 with a random pc reloads a register with a fresh value
				rtie_pkg::FN_JALR: begin rs = (k < 40) ? 0 : rs; rt = 0; sh = 0; end
				default: sh = 0;
			endcase
		end
		return mk(fn, rs, rt, rd, sh);
	endfunction

	task automatic add_instr(logic [31:0] w, logic [31:0] pc);
		pending_instrs.push_back('{instr: w, pc: pc});
		expected_results.push_back(execute_instr(w, pc));
	endtask

	task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$error("%s expected %h actual %h", name, e, a);
			errors++;
		end
	endtask

	// stimulus and reset
	initial begin
		logic [31:0] pc;
		for (int i = 0; i < 32; i++) gpr_model[i] = '0;
		hi_model = '0;
		lo_model = '0;
		// load registers through the link of jalr from r0
		add_instr(mk(rtie_pkg::FN_JALR, 0, 0, 1, 0), 32'h7FFF_FFF8);
		add_instr(mk(rtie_pkg::FN_JALR, 0, 0, 2, 0), 32'hFFFF_FFF7);
		add_instr(mk(rtie_pkg::FN_JALR, 0, 0, 3, 0), 32'h0000_0001);
		add_instr(mk(rtie_pkg::FN_JALR, 0, 0, 4, 0), 32'h7FFF_FFF7);
		add_instr(mk(rtie_pkg::FN_JALR, 0, 0, 5, 0), 32'hFFFF_FFF8);
		for (int i = 6; i < 32; i++) add_instr(mk(rtie_pkg::FN_JALR, 0, 0, i, 0), $urandom());
		// corner cases
		add_instr(mk(rtie_pkg::FN_DIV, 1, 2, 0, 0), 32'h100);
		add_instr(mk(rtie_pkg::FN_MFHI, 0, 0, 8, 0), 32'h104);
		add_instr(mk(rtie_pkg::FN_DIV, 4, 0, 0, 0), 32'h108);
		add_instr(mk(rtie_pkg::FN_DIVU, 4, 0, 7, 3), 32'h10C);
		add_instr(mk(rtie_pkg::FN_DIV, 2, 6, 0, 0), 32'h110);
		add_instr(mk(rtie_pkg::FN_MFLO, 0, 0, 9, 0), 32'h114);
		add_instr(mk(rtie_pkg::FN_ADD, 1, 1, 10, 0), 32'h118);
		add_instr(mk(rtie_pkg::FN_SUB, 1, 4, 10, 0), 32'h11C);
		add_instr(mk(rtie_pkg::FN_ADD, 4, 4, 10, 0), 32'h120);
		add_instr(mk(rtie_pkg::FN_JR, 3, 0, 0, 0), 32'h124);
		add_instr(mk(rtie_pkg::FN_JALR, 4, 0, 11, 0), 32'h128);
		add_instr(mk(rtie_pkg::FN_JR, 1, 2, 0, 3), 32'h12C);
		add_instr(mk(rtie_pkg::FN_MULT, 1, 2, 0, 0), 32'h130);
		add_instr(mk(rtie_pkg::FN_MFHI, 0, 0, 12, 0), 32'h134);
		add_instr(mk(rtie_pkg::FN_MULTU, 2, 2, 0, 0), 32'h138);
		add_instr(mk(rtie_pkg::FN_MFLO, 0, 0, 13, 0), 32'h13C);
		add_instr(mk(rtie_pkg::FN_JALR, 5, 0, 5, 0), 32'h140);
		add_instr(mk(rtie_pkg::FN_SRAV, 1, 2, 14, 0), 32'h144);
		add_instr(mk(rtie_pkg::FN_SRA, 0, 1, 15, 31), 32'h148);
		pc = 32'h1000;
		for (int i = 0; i < NumRandom; i++) begin
			if ($urandom_range(9) == 0) pc = $urandom();
			add_instr(rand_instr(), pc);
			pc = pc + 32'd4;
		end
		total_items = pending_instrs.size();
		gen_done = 1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// input acceptance
	always @(posedge clk) begin
		last_acc = 1'b0;
		if (arst_n && push && full) full_seen = 1'b1;
		if (arst_n && push && !full) begin
			last_acc = 1'b1;
			accepted++;
			void'(pending_instrs.pop_front());
		end
	end

	// driver: bursts and gaps; an offered item stays until it is taken
	always @(negedge clk) begin
		if (arst_n && gen_done) begin
			if (push && !last_acc) begin
				push <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				push <= 1'b0;
			end else if (pending_instrs.size() > 0) begin
				push       <= 1'b1;
				instr_word <= pending_instrs[0].instr;
				current_pc <= pending_instrs[0].pc;
				if (burst_left > 0) burst_left--;
				else begin
					burst_left = $urandom_range(12);
					gap_left   = $urandom_range(5);
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		pop <= arst_n && !long_hold && ((pop_cnt % 7) >= 2) && ($urandom_range(9) != 0);
		pop_cnt++;
	end

	// one long output stall while the sender keeps offering
	initial begin
		wait (accepted >= 100);
		@(negedge clk);
		long_hold = 1'b1;
		repeat (60) @(posedge clk);
		@(negedge clk);
		long_hold = 1'b0;
		long_hold_done = 1'b1;
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result item");
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				check_field("next_pc", exp_r.npc, next_pc);
				check_field("delay_slot_pending", 32'(exp_r.dsp), 32'(delay_slot_pending));
				check_field("delay_slot_pc", exp_r.dspc, delay_slot_pc);
				check_field("reg_write_en", 32'(exp_r.we), 32'(reg_write_en));
				check_field("reg_write_index", 32'(exp_r.widx), 32'(reg_write_index));
				check_field("reg_write_value", exp_r.wval, reg_write_value);
				check_field("status", 32'(exp_r.st), 32'(status));
				unique case (exp_r.st)
					rtie_pkg::ST_OVF:      n_ovf++;
					rtie_pkg::ST_MISALIGN: n_misalign++;
					rtie_pkg::ST_INVALID:  n_invalid++;
					default: if (exp_r.dsp) n_jump++;
				endcase
			end
			retired++;
			if (gen_done && retired == total_items) begin
				$display("ran %0d items: %0d overflow, %0d misaligned, %0d invalid, %0d jumps",
					retired, n_ovf, n_misalign, n_invalid, n_jump);
				$display("long output stall done: %0d, input held off by full: %0d",
					long_hold_done, full_seen);
				if (errors == 0 && expected_results.size() == 0) $display("TEST PASSED");
				else $display("TEST FAILED");
				$finish;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$error("run limit reached with %0d of %0d items retired", retired, total_items);
			$display("TEST FAILED");
			$finish;
		end
	end
endmodule
